@@ rtl/md5_message_digest_core_assert.svh @@
`ifndef MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define MD5_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("md5 core check failed");

// next-cycle implication, checked on clk outside reset
`define MD5_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("md5 core check failed");

`endif

@@ rtl/md5_pkg.sv @@
package md5_pkg;

  // microcode addresses
  typedef logic [3:0] upc_t;
  localparam upc_t U_ACC   = 4'd0;
  localparam upc_t U_PAD   = 4'd1;
  localparam upc_t U_ZERO  = 4'd2;
  localparam upc_t U_OUT   = 4'd3;
  localparam upc_t U_LENLO = 4'd4;
  localparam upc_t U_LENHI = 4'd5;
  localparam upc_t U_PREF  = 4'd6;
  localparam upc_t U_RND   = 4'd7;
  localparam upc_t U_ADD   = 4'd8;

  // datapath operations
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_ACC   = 4'd1;
  localparam logic [3:0] OP_PAD   = 4'd2;
  localparam logic [3:0] OP_ZERO  = 4'd3;
  localparam logic [3:0] OP_OUT   = 4'd4;
  localparam logic [3:0] OP_LENLO = 4'd5;
  localparam logic [3:0] OP_LENHI = 4'd6;
  localparam logic [3:0] OP_PREF  = 4'd7;
  localparam logic [3:0] OP_RND   = 4'd8;
  localparam logic [3:0] OP_ADD   = 4'd9;

  // sequencer jump conditions
  localparam logic [2:0] CND_NEXT = 3'd0;
  localparam logic [2:0] CND_JUMP = 3'd1;
  localparam logic [2:0] CND_ACC  = 3'd2;
  localparam logic [2:0] CND_ZERO = 3'd3;
  localparam logic [2:0] CND_LOOP = 3'd4;
  localparam logic [2:0] CND_DISP = 3'd5;
  localparam logic [2:0] CND_OUT  = 3'd6;

  // finishing phase, order matches the dispatch targets after U_ACC
  localparam logic [1:0] PH_NORM = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_PAD2 = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cnd;
    upc_t       tgt;
    upc_t       alt;
  } ucw_t;

  typedef struct packed {
    logic       acc;
    logic       full;
    logic       last;
    logic       zdone;
    logic       pad2;
    logic       rnd_end;
    logic [1:0] ph;
    logic       out_free;
  } seq_stat_t;

  function automatic ucw_t md5_ucode(upc_t a);
    ucw_t w;
    unique case (a)
      U_ACC:   w = '{op: OP_ACC,   cnd: CND_ACC,  tgt: U_PAD,   alt: U_PREF};
      U_PAD:   w = '{op: OP_PAD,   cnd: CND_NEXT, tgt: U_ACC,   alt: U_ACC};
      U_ZERO:  w = '{op: OP_ZERO,  cnd: CND_ZERO, tgt: U_LENLO, alt: U_PREF};
      U_OUT:   w = '{op: OP_OUT,   cnd: CND_OUT,  tgt: U_ACC,   alt: U_ACC};
      U_LENLO: w = '{op: OP_LENLO, cnd: CND_NEXT, tgt: U_ACC,   alt: U_ACC};
      U_LENHI: w = '{op: OP_LENHI, cnd: CND_JUMP, tgt: U_PREF,  alt: U_ACC};
      U_PREF:  w = '{op: OP_PREF,  cnd: CND_NEXT, tgt: U_ACC,   alt: U_ACC};
      U_RND:   w = '{op: OP_RND,   cnd: CND_LOOP, tgt: U_ADD,   alt: U_ACC};
      U_ADD:   w = '{op: OP_ADD,   cnd: CND_DISP, tgt: U_ACC,   alt: U_ACC};
      default: w = '{op: OP_IDLE,  cnd: CND_JUMP, tgt: U_ACC,   alt: U_ACC};
    endcase
    return w;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] md5_widx(logic [5:0] i);
    logic [3:0] j;
    logic [3:0] r;
    j = i[3:0];
    case (i[5:4])
      2'd0:    r = j;
      2'd1:    r = j + {j[1:0], 2'b00} + 4'd1;
      2'd2:    r = j + {j[2:0], 1'b0} + 4'd5;
      default: r = {j[0], 3'b000} - j;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] md5_rot(logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md5_k(logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/md5_seq.sv @@
module md5_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  md5_pkg::seq_stat_t stat,
  output md5_pkg::ucw_t      ctrl
);
  import md5_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  ucw_t uw;

  assign uw   = md5_ucode(upc_r);
  assign ctrl = uw;

  always_comb begin
    upc_nxt = upc_r;
    unique case (uw.cnd)
      CND_NEXT: upc_nxt = upc_r + 4'd1;
      CND_JUMP: upc_nxt = uw.tgt;
      CND_ACC: begin
        if (stat.acc && stat.full) upc_nxt = uw.alt;
        else if (stat.acc && stat.last) upc_nxt = uw.tgt;
      end
      CND_ZERO: begin
        if (stat.zdone) upc_nxt = stat.pad2 ? uw.alt : uw.tgt;
      end
      CND_LOOP: begin
        if (stat.rnd_end) upc_nxt = uw.tgt;
      end
      CND_DISP: upc_nxt = uw.tgt + {2'b00, stat.ph};
      CND_OUT: begin
        if (stat.out_free) upc_nxt = uw.tgt;
      end
      default: upc_nxt = U_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upc_r <= U_ACC;
    else upc_r <= upc_nxt;
  end

endmodule

@@ rtl/md5_message_digest_core.sv @@
// md5 digest core: one message byte per beat, one 4-word digest per message
// bytes are taken only in the accumulate state; every 64th byte starts a compression
// (prefetch, 64 rounds at one per cycle, chaining add), and no byte is taken meanwhile
// last byte: padding, zero fill and the length words, a compression, then output when free;
// a spill adds a zero-filled block and its compression; a full last block is compressed first
// reset (rst_n low, synchronous): initial words, zero bit count, empty output, buffer uncleared
`include "md5_message_digest_core_assert.svh"

module md5_message_digest_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] message_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [31:0] digest_word_a, [63:32] digest_word_b,
                                   // [95:64] digest_word_c, [127:96] digest_word_d
);
  import md5_pkg::*;

  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  // sequencer
  ucw_t      ctrl;
  seq_stat_t stat;

  md5_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  // message state
  logic [5:0]  fill_r;        // bytes held in the current block
  logic [31:0] word_r;        // little-endian word being assembled, newest byte on top
  logic [63:0] bitcnt_r;
  logic [1:0]  ph_r;          // what follows the next chaining add
  logic        pad2_r;        // length spills into a second block
  logic [4:0]  wptr_r;        // zero fill word pointer, may reach 16

  // chaining and working words
  logic [31:0] cha_r, chb_r, chc_r, chd_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [5:0]  rnd_r;

  // block buffer, one 32-bit word per entry
  logic [31:0] mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_r;

  // output register
  logic         out_valid_r;
  logic [127:0] out_data_r;

  logic        in_acc;
  logic        out_free;
  logic        zdone;
  logic [31:0] byte_word;
  logic [31:0] pad_word;

  assign in_tready  = (ctrl.op == OP_ACC);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign zdone     = (wptr_r == (pad2_r ? 5'd16 : 5'd14));
  assign byte_word = {in_tdata, word_r[31:8]};

  // partial word plus the 0x80 marker, zeros above it
  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_word = {24'h000000, 8'h80};
      2'd1:    pad_word = {16'h0000, 8'h80, word_r[31:24]};
      2'd2:    pad_word = {8'h00, 8'h80, word_r[31:16]};
      default: pad_word = {8'h80, word_r[31:8]};
    endcase
  end

  assign stat = '{acc:      in_acc,
                  full:     (fill_r == 6'd63),
                  last:     in_tlast,
                  zdone:    zdone,
                  pad2:     pad2_r,
                  rnd_end:  (rnd_r == 6'd63),
                  ph:       ph_r,
                  out_free: out_free};

  // buffer write and read address selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_r[5:2];
    mem_wdata = byte_word;
    mem_raddr = 4'd0;
    case (ctrl.op)
      OP_ACC: begin
        mem_we = in_acc && (fill_r[1:0] == 2'd3);
      end
      OP_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = pad_word;
      end
      OP_ZERO: begin
        mem_we    = !zdone;
        mem_waddr = wptr_r[3:0];
        mem_wdata = 32'h0;
      end
      OP_LENLO: begin
        mem_we    = 1'b1;
        mem_waddr = LEN_LO_WORD;
        mem_wdata = bitcnt_r[31:0];
      end
      OP_LENHI: begin
        mem_we    = 1'b1;
        mem_waddr = LEN_HI_WORD;
        mem_wdata = bitcnt_r[63:32];
      end
      OP_PREF:  mem_raddr = md5_widx(6'd0);
      OP_RND:   mem_raddr = md5_widx(rnd_r + 6'd1);   // word for the next round
      default:  mem_raddr = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // one md5 round
  logic [31:0] rf;
  logic [31:0] rt;
  logic [31:0] rrot;
  logic [4:0]  rs;

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    rf = (wb_r & wc_r) | (~wb_r & wd_r);
      2'd1:    rf = (wb_r & wd_r) | (wc_r & ~wd_r);
      2'd2:    rf = wb_r ^ wc_r ^ wd_r;
      default: rf = wc_r ^ (wb_r | ~wd_r);
    endcase
    rt   = wa_r + rf + mem_rdata_r + md5_k(rnd_r);
    rs   = md5_rot(rnd_r);
    rrot = (rt << rs) | (rt >> (6'd32 - {1'b0, rs}));
  end

  // working words and round counter
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PREF: begin
        wa_r  <= cha_r;
        wb_r  <= chb_r;
        wc_r  <= chc_r;
        wd_r  <= chd_r;
        rnd_r <= 6'd0;
      end
      OP_RND: begin
        wa_r  <= wd_r;
        wd_r  <= wc_r;
        wc_r  <= wb_r;
        wb_r  <= wb_r + rrot;
        rnd_r <= rnd_r + 6'd1;
      end
      default: ;
    endcase
  end

  // byte assembly and zero-fill pointer, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) word_r <= byte_word;
    case (ctrl.op)
      OP_PAD:  wptr_r <= {1'b0, fill_r[5:2]} + 5'd1;
      OP_ZERO: begin
        if (!zdone) wptr_r <= wptr_r + 5'd1;
        else if (pad2_r) wptr_r <= 5'd0;       // second block starts empty
      end
      default: ;
    endcase
  end

  // message control state and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 6'd0;
      bitcnt_r <= 64'd0;
      ph_r     <= PH_NORM;
      pad2_r   <= 1'b0;
      cha_r    <= IV_A;
      chb_r    <= IV_B;
      chc_r    <= IV_C;
      chd_r    <= IV_D;
    end else begin
      case (ctrl.op)
        OP_ACC: begin
          if (in_acc) begin
            fill_r   <= fill_r + 6'd1;
            bitcnt_r <= bitcnt_r + 64'd8;
            // last byte that completes a block: pad after this compression
            if (fill_r == 6'd63 && in_tlast) ph_r <= PH_PAD;
          end
        end
        OP_PAD: begin
          pad2_r <= (fill_r[5:2] >= 4'd14);
        end
        OP_ZERO: begin
          if (zdone && pad2_r) begin
            pad2_r <= 1'b0;
            ph_r   <= PH_PAD2;
          end
        end
        OP_LENHI: ph_r <= PH_FIN;
        OP_ADD: begin
          cha_r <= cha_r + wa_r;
          chb_r <= chb_r + wb_r;
          chc_r <= chc_r + wc_r;
          chd_r <= chd_r + wd_r;
          ph_r  <= PH_NORM;
        end
        OP_OUT: begin
          // digest handed to the output register, back to a fresh message
          if (out_free) begin
            fill_r   <= 6'd0;
            bitcnt_r <= 64'd0;
            cha_r    <= IV_A;
            chb_r    <= IV_B;
            chc_r    <= IV_C;
            chd_r    <= IV_D;
          end
        end
        default: ;
      endcase
    end
  end

  // output register, frees the core while the digest waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT && out_free) out_data_r <= {chd_r, chc_r, chb_r, cha_r};
  end

  // checks
  `MD5_ASSERT_NOW(a_no_write_in_rounds, ctrl.op == OP_RND, !mem_we)
  `MD5_ASSERT_NEXT(a_full_block_compresses, in_acc && fill_r == 6'd63, ctrl.op == OP_PREF)
  `MD5_ASSERT_NEXT(a_out_restarts_msg, ctrl.op == OP_OUT && out_free,
                   cha_r == IV_A && bitcnt_r == 64'd0 && out_tvalid)

endmodule

@@ test/md5_digest_checker.sv @@
`timescale 1ns / 1ps

module md5_digest_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         run_done,
  output int           mismatches,
  output int           digests_pending,
  output int           digests_checked
);

  // additive constants per round, round 0 first
  localparam logic [0:63][31:0] ROUND_ADD = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, four per round group
  localparam logic [0:15][4:0] ROUND_ROT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam int LENGTH_OFFSET = 56;

  logic [31:0]  chain [4];
  logic [63:0]  msg_bits;
  logic [7:0]   block_bytes [64];
  logic [5:0]   fill;
  logic [127:0] expected_digests [$];
  bit           leftovers_checked;

  function automatic void restart_digest();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    msg_bits = '0;
    fill     = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          k;
    int          grp;
    int          s;
    for (int j = 0; j < 16; j++)
      w[j] = {block_bytes[4*j+3], block_bytes[4*j+2], block_bytes[4*j+1], block_bytes[4*j]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          k = i % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          k = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          k = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          k = (7 * i) % 16;
        end
      endcase
      t = a + f + w[k] + ROUND_ADD[i];
      s = ROUND_ROT[grp*4 + i%4];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // takes one byte; on the final byte pads, finishes and queues the digest
  function automatic void absorb_message_byte(logic [7:0] value, logic final_byte);
    logic [63:0] length_bits;
    int          pos;
    block_bytes[fill] = value;
    msg_bits = msg_bits + 64'd8;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
    if (!final_byte) return;
    length_bits = msg_bits;
    pos = fill;
    block_bytes[pos] = 8'h80;
    pos++;
    // length no longer fits: flush a zero-filled block first
    if (pos > LENGTH_OFFSET) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < LENGTH_OFFSET) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (int j = 0; j < 8; j++) block_bytes[LENGTH_OFFSET + j] = length_bits[8*j +: 8];
    compress_block();
    expected_digests.push_back({chain[3], chain[2], chain[1], chain[0]});
    restart_digest();
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    mismatches        = 0;
    digests_pending   = 0;
    digests_checked   = 0;
    leftovers_checked = 0;
    restart_digest();
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      restart_digest();
      expected_digests.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch($sformatf("digest %h with no message pending", out_tdata));
        end else begin
          want = expected_digests.pop_front();
          digests_checked++;
          for (int i = 0; i < 4; i++)
            if (out_tdata[32*i +: 32] !== want[32*i +: 32])
              report_mismatch($sformatf("digest %0d, digest_word_%c: got %h, expected %h",
                                        digests_checked, 8'h61 + i,
                                        out_tdata[32*i +: 32], want[32*i +: 32]));
        end
      end
      if (in_tvalid && in_tready) absorb_message_byte(in_tdata, in_tlast);
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1;
        if (expected_digests.size() != 0)
          report_mismatch($sformatf("%0d digests never came out", expected_digests.size()));
      end
    end
    digests_pending = expected_digests.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // rough stimulus size, the current message is always finished
  localparam int BYTE_TARGET = 750;
  // settle time once the last digest is out; a message never ends without one
  localparam int TAIL_CYCLES = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;   // [7:0] message_byte
  logic         in_tlast = 1'b0;    // last_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;          // [31:0] a, [63:32] b, [95:64] c, [127:96] d
  logic         run_done = 1'b0;

  int mismatches;
  int digests_pending;
  int digests_checked;

  // sender bookkeeping for the summary
  int messages_sent;
  int bytes_sent;
  int longest_message;

  // receiver stall state
  int stall_left;
  int calm_left;

  always #5 clk = ~clk;

  md5_message_digest_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  md5_digest_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .run_done        (run_done),
    .mismatches      (mismatches),
    .digests_pending (digests_pending),
    .digests_checked (digests_checked)
  );

  // idle length: mostly a few cycles, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // message length: mostly short, some spanning a few blocks
  function automatic int message_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 80);
    return $urandom_range(100, 130);
  endfunction

  // receiver: random stalls, with calm stretches of always-ready
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 9) < 3) stall_left = gap_length();
      else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(50, 300);
    end
  end

  // drop valid for a number of cycles; zero keeps the bus busy
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // present one byte beat and wait for the handshake
  task automatic send_byte(input logic [7:0] value, input logic final_byte);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= final_byte;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (final_byte) messages_sent++;
  endtask

  // stop sending until every queued digest has come out
  task automatic drain_digests();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (digests_pending != 0) @(negedge clk);
  endtask

  // one message of random bytes; some are a single repeated extreme value
  task automatic send_random_message(input int len);
    bit         calm;
    int         fill_mode;
    logic [7:0] value;
    calm = ($urandom_range(0, 3) == 0);
    fill_mode = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      if (!calm && $urandom_range(0, 1) == 0) hold_off(gap_length());
      if (fill_mode == 0) value = 8'h00;
      else if (fill_mode == 1) value = 8'hff;
      else value = $urandom_range(0, 255);
      send_byte(value, i == len - 1);
    end
    if (len > longest_message) longest_message = len;
  endtask

  initial begin : stimulus
    // lengths around the padding boundaries: 55 pads in one block, 56 needs two,
    // 63 leaves one free byte, 64 fills the block with the last byte
    int edge_lengths [4];
    edge_lengths = '{55, 56, 63, 64};
    messages_sent = 0;
    bytes_sent = 0;
    longest_message = 1;
    stall_left = 0;
    calm_left = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // single-byte messages at the byte extremes and the pad value itself
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b1);
    // the classic three-byte text
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    // extremes next to each other in one message
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    drain_digests();

    foreach (edge_lengths[i]) send_random_message(edge_lengths[i]);

    // random messages; now and then wait until every queued digest is out
    while (bytes_sent < BYTE_TARGET) begin
      send_random_message(message_length());
      if ($urandom_range(0, 15) == 0) drain_digests();
    end

    drain_digests();
    repeat (TAIL_CYCLES) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("ran %0d messages, %0d bytes, longest %0d bytes",
             messages_sent, bytes_sent, longest_message);
    $display("compared %0d digests, including the one- and two-block padding cases",
             digests_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
